### rtl/bdet_pkg.sv
// Package for the 4x4 fraction-free determinant block.
// Holds fixed sizes, the sequencer state type and channel widths.
// No dependencies.
package bdet_pkg;

    localparam int ORDER    = 4;
    localparam int IDX_W    = 2;                // row or column index
    localparam int CELLS    = ORDER * ORDER;
    localparam int ADDR_W   = 2 * IDX_W;        // row-major address {row, col}
    localparam int VAL_W    = 10;               // loaded entry width
    localparam int POS_W    = 4;                // entry position width
    localparam int DET_W    = 42;               // determinant / work entry width
    localparam int OP_W     = 32;               // multiplier operand width
    localparam int PROD_W   = 2 * OP_W;         // product width
    localparam int QW       = DET_W - 1;        // quotient magnitude bits
    localparam int DSH_W    = OP_W + QW - 1;    // aligned divisor width
    localparam int CNT_W    = 6;                // divider step counter

    localparam int S_TDATA_W = 16;              // value + position, byte padded
    localparam int M_TDATA_W = 48;              // determinant, byte padded

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_LEAD_RD,
        ST_LEAD_WT,
        ST_OP_RD,
        ST_MUL,
        ST_SUB,
        ST_DIV_INIT,
        ST_DIV,
        ST_WR,
        ST_FIN_RD,
        ST_FIN_WT,
        ST_EMIT
    } bdet_state_t;

endpackage

### rtl/bareiss_determinant_4x4.sv
// Top level of the 4x4 fraction-free (Bareiss) determinant engine.
// Depends on bdet_pkg for sizes and the sequencer state type.
//
// Usage: stream the 16 matrix entries in, one transaction each, with the
// row-major position (row*4+col) beside the value. Entries are held in a load
// memory and may be rewritten in any order; the transaction that carries
// position 15 writes its entry and starts elimination on the whole stored
// matrix. The loaded entries are kept, so rewriting a few entries and then
// position 15 again gives the determinant of the updated matrix. One result
// transaction follows each elimination: the 42-bit determinant, and a flag in
// m_tuser that is set when a leading pivot (a00, then the reduced a11, a22)
// was zero, in which case the determinant is reported as 0. No row swaps are
// done. A full elimination runs 14 cell updates, each of them one operand
// read of two cells, a multiply, a subtract, a divider setup, 41
// restoring-divider steps of one quotient bit each for the exact division
// by the previous pivot, and one write-back. Each of the 3 pivot steps
// first reads its pivot, each of the 6 row passes reads its row lead, and
// a final read and an emit state close the run. A zero pivot ends the run
// early. s_tready is low while elimination runs. The first pivot step reads
// straight from the load memory and writes the work memory; later steps
// work on the work memory alone.
module bareiss_determinant_4x4 (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [9:0] entry_value (signed), [13:10] entry_position, [15:14] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bdet_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [41:0] determinant (signed), [47:42] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdet_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: [0] zero_pivot
    output logic                           m_tuser
);
    import bdet_pkg::*;

    // ---------------------------------------------------------------
    // Memories: loaded entries and the elimination work copy.
    // Two read ports each, read data registered.
    // ---------------------------------------------------------------
    logic [VAL_W-1:0] ld_mem [CELLS];
    logic [DET_W-1:0] wk_mem [CELLS];

    logic [VAL_W-1:0]  ld_a_reg, ld_b_reg;
    logic [DET_W-1:0]  wk_a_reg, wk_b_reg;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic              ld_we, wk_we;
    logic [DET_W-1:0]  wk_wdata;

    logic [VAL_W-1:0] in_value;
    logic [POS_W-1:0] in_pos;

    assign in_value = s_tdata[VAL_W-1:0];
    assign in_pos   = s_tdata[VAL_W+POS_W-1:VAL_W];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    bdet_state_t state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             flag_reg, flag_next;
    logic signed [OP_W-1:0] prev_reg, prev_next;   // previous pivot
    logic [OP_W-1:0]        dabs_reg, dabs_next;   // |previous pivot|

    logic signed [OP_W-1:0]   pivot_reg, pivot_next;
    logic signed [OP_W-1:0]   lead_reg, lead_next;
    logic signed [PROD_W-1:0] prod_l_reg, prod_l_next;
    logic signed [PROD_W-1:0] prod_r_reg, prod_r_next;
    logic signed [PROD_W-1:0] diff_reg, diff_next;
    logic [PROD_W-1:0]        rem_reg, rem_next;
    logic [DSH_W-1:0]         dsh_reg, dsh_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DET_W-1:0]         det_reg, det_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DET_W-1:0]         m_det_reg, m_det_next;
    logic                     m_flag_reg, m_flag_next;

    // operand views of read port data: step 0 reads the loaded entries
    logic signed [OP_W-1:0] rd_a_op, rd_b_op;
    logic [DSH_W:0]         trial;
    logic [DET_W-1:0]       quo_signed;

    always_comb begin
        if (k_reg == '0) begin
            rd_a_op = {{(OP_W-VAL_W){ld_a_reg[VAL_W-1]}}, ld_a_reg};
            rd_b_op = {{(OP_W-VAL_W){ld_b_reg[VAL_W-1]}}, ld_b_reg};
        end else begin
            rd_a_op = wk_a_reg[OP_W-1:0];
            rd_b_op = wk_b_reg[OP_W-1:0];
        end
    end

    // one restoring-division step against the aligned divisor
    assign trial = {1'b0, {(DSH_W-PROD_W){1'b0}}, rem_reg} - {1'b0, dsh_reg};

    assign quo_signed = neg_reg ? DET_W'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
    assign wk_wdata   = quo_signed;

    // ---------------------------------------------------------------
    // Sequencer: next state and datapath controls
    // ---------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        flag_next     = flag_reg;
        prev_next     = prev_reg;
        dabs_next     = dabs_reg;
        pivot_next    = pivot_reg;
        lead_next     = lead_reg;
        prod_l_next   = prod_l_reg;
        prod_r_next   = prod_r_reg;
        diff_next     = diff_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        det_next      = det_reg;
        m_det_next    = m_det_reg;
        m_flag_next   = m_flag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wk_we         = 1'b0;
        s_tready      = 1'b0;
        addr_a        = {k_reg, k_reg};
        addr_b        = {i_reg, j_reg};

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_pos == LAST_POS) begin
                    k_next     = '0;
                    prev_next  = OP_W'(1);
                    dabs_next  = OP_W'(1);
                    flag_next  = 1'b0;
                    state_next = ST_PIV_RD;
                end
            end
            ST_PIV_RD: begin
                addr_a     = {k_reg, k_reg};
                state_next = ST_PIV_WT;
            end
            ST_PIV_WT: begin
                pivot_next = rd_a_op;
                if (rd_a_op == '0) begin
                    flag_next  = 1'b1;
                    det_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    i_next     = k_reg + IDX_W'(1);
                    state_next = ST_LEAD_RD;
                end
            end
            ST_LEAD_RD: begin
                addr_a     = {i_reg, k_reg};
                state_next = ST_LEAD_WT;
            end
            ST_LEAD_WT: begin
                lead_next  = rd_a_op;
                j_next     = k_reg + IDX_W'(1);
                state_next = ST_OP_RD;
            end
            ST_OP_RD: begin
                addr_a     = {k_reg, j_reg};
                addr_b     = {i_reg, j_reg};
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_l_next = PROD_W'(pivot_reg) * PROD_W'(rd_b_op);
                prod_r_next = PROD_W'(lead_reg) * PROD_W'(rd_a_op);
                state_next  = ST_SUB;
            end
            ST_SUB: begin
                diff_next  = prod_l_reg - prod_r_reg;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                rem_next   = diff_reg[PROD_W-1] ? PROD_W'(-diff_reg) : diff_reg;
                neg_next   = diff_reg[PROD_W-1] ^ prev_reg[OP_W-1];
                dsh_next   = {dabs_reg, {(QW-1){1'b0}}};
                quo_next   = '0;
                cnt_next   = CNT_W'(QW - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!trial[DSH_W]) begin
                    rem_next = trial[PROD_W-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                wk_we = 1'b1;
                if (j_reg == IDX_W'(ORDER - 1)) begin
                    if (i_reg == IDX_W'(ORDER - 1)) begin
                        // pivot step done
                        prev_next = pivot_reg;
                        dabs_next = pivot_reg[OP_W-1] ? OP_W'(-pivot_reg) : pivot_reg;
                        if (k_reg == IDX_W'(ORDER - 2)) begin
                            state_next = ST_FIN_RD;
                        end else begin
                            k_next     = k_reg + IDX_W'(1);
                            state_next = ST_PIV_RD;
                        end
                    end else begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_LEAD_RD;
                    end
                end else begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_OP_RD;
                end
            end
            ST_FIN_RD: begin
                addr_a     = ADDR_W'(CELLS - 1);
                state_next = ST_FIN_WT;
            end
            ST_FIN_WT: begin
                det_next   = wk_a_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // output register is free or being drained this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_det_next    = det_reg;
                    m_flag_next   = flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ld_we = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            ld_mem[in_pos] <= in_value;
        end
        ld_a_reg <= ld_mem[addr_a];
        ld_b_reg <= ld_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (wk_we) begin
            wk_mem[{i_reg, j_reg}] <= wk_wdata;
        end
        wk_a_reg <= wk_mem[addr_a];
        wk_b_reg <= wk_mem[addr_b];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= OP_W'(1);
            dabs_reg     <= OP_W'(1);
            flag_reg     <= 1'b0;
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            prev_reg     <= prev_next;
            dabs_reg     <= dabs_next;
            flag_reg     <= flag_next;
            k_reg        <= k_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            cnt_reg      <= cnt_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        pivot_reg  <= pivot_next;
        lead_reg   <= lead_next;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        diff_reg   <= diff_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        det_reg    <= det_next;
        m_det_reg  <= m_det_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DET_W){1'b0}}, m_det_reg};
    assign m_tuser  = m_flag_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // a new result only comes out of the emit state
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |->
            $past(state_reg == ST_EMIT))
        else $error("result appeared without passing through emit");

    // a zero pivot always reports a zero determinant
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[DET_W-1:0] == '0))
        else $error("zero pivot flagged with nonzero determinant");

    // Bareiss division is exact: nothing left over at write-back
    a_exact_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |-> (rem_reg == '0))
        else $error("division by previous pivot left a remainder");

endmodule

### bench/bareiss_determinant_4x4_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the 4x4 fraction-free determinant engine.
// Needs bdet_pkg and bareiss_determinant_4x4 from the rtl folder; nothing else.
module bareiss_determinant_4x4_test;
    import bdet_pkg::*;

    // Sizing of the run
    localparam int ITEM_TARGET  = 1600;       // entry transactions, roughly
    localparam int DRAIN_CYCLES = 800;        // one elimination plus margin
    localparam int CYCLE_LIMIT  = 5_000_000;  // hang guard
    localparam int MAX_PAUSE    = 16;
    localparam int REPORT_MAX   = 10;

    // What one determinant transaction carries
    typedef struct packed {
        logic [DET_W-1:0] determinant;
        logic             zero_pivot;
    } det_result_t;

    // One row of the directed table; typed rows carry a hand-written answer
    typedef struct {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        bit               typed;
        det_result_t      result;
    } load_row_t;

    // Flavors of random matrix content
    typedef enum int {
        MIX_FULL,    // whole 10-bit range
        MIX_TINY,    // -2..2, lots of zero pivots and singular matrices
        MIX_EDGE,    // only -512, 511, -1, 1 and 0
        MIX_NARROW   // -8..8
    } value_mix_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [9:0] value, [13:10] position, [15:14] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [41:0] determinant, [47:42] zero
    logic                 m_tuser;         // [0] zero_pivot

    // Shadow of the block's load memory, as signed integers
    longint      loaded_cell [CELLS];
    // Determinants still owed by the block, oldest first
    det_result_t expected_dets [$];
    load_row_t   load_table [$];
    det_result_t oldest_det;

    int          items_sent     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          no_idle        = 1'b0;   // stretches of back-to-back traffic

    bareiss_determinant_4x4 i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 100 MHz
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Bareiss elimination over the shadow memory, no row swaps. Divisions are
    // exact, so plain signed division matches. A zero leading pivot stops the
    // elimination and reports determinant 0 with the flag set.
    function automatic det_result_t bareiss_det();
        longint      m [CELLS];
        longint      pivot;
        longint      lead;
        longint      prior;
        det_result_t r;
        m     = loaded_cell;
        prior = 1;
        r     = '0;
        for (int k = 0; k < ORDER - 1 && !r.zero_pivot; k++) begin
            pivot = m[k * ORDER + k];
            if (pivot == 0) begin
                r.zero_pivot = 1'b1;
            end else begin
                for (int i = k + 1; i < ORDER; i++) begin
                    lead = m[i * ORDER + k];
                    for (int j = k + 1; j < ORDER; j++)
                        m[i * ORDER + j] =
                            (pivot * m[i * ORDER + j] - lead * m[k * ORDER + j]) / prior;
                end
                prior = pivot;
            end
        end
        if (!r.zero_pivot)
            r.determinant = DET_W'(m[CELLS - 1]);
        return r;
    endfunction

    function automatic int draw_pause();
        return no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    function automatic logic [VAL_W-1:0] draw_value(value_mix_t mix);
        logic [VAL_W-1:0] v;
        case (mix)
            MIX_TINY:   v = VAL_W'($urandom_range(0, 4) - 2);
            MIX_NARROW: v = VAL_W'($urandom_range(0, 16) - 8);
            MIX_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       v = 10'h200;   // -512
                    1:       v = 10'h1FF;   // 511
                    2:       v = 10'h3FF;   // -1
                    3:       v = 10'h001;
                    default: v = '0;
                endcase
            end
            default:    v = VAL_W'($urandom_range(0, 1023));
        endcase
        return v;
    endfunction

    function automatic void add_row(int value, int position, bit typed, longint det, bit flag);
        load_row_t row;
        row.value                = VAL_W'(value);
        row.position             = POS_W'(position);
        row.typed                = typed;
        row.result.determinant   = DET_W'(det);
        row.result.zero_pivot    = flag;
        load_table.push_back(row);
    endfunction

    // Send one entry transaction. tvalid stays high into the next entry when
    // no pause is drawn, so this task only lowers it at the start of a pause.
    // Position 15 launches an elimination, so its determinant is queued here.
    task automatic send_entry(input logic [VAL_W-1:0] value, input logic [POS_W-1:0] position,
                              input bit typed, input det_result_t typed_result);
        int gap;
        gap = draw_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, position, value};
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
        loaded_cell[position] = $signed(value);
        if (position == LAST_POS)
            expected_dets.push_back(typed ? typed_result : bareiss_det());
    endtask

    // Result side: a fresh stall is drawn for every determinant transaction
    initial begin
        int stall;
        forever begin
            stall = draw_pause();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Compare every determinant transaction with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_dets.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected determinant %0d flag %0b at cycle %0d",
                             $signed(m_tdata[DET_W-1:0]), m_tuser, cycle_count);
            end else begin
                oldest_det = expected_dets.pop_front();
                if (m_tdata[DET_W-1:0] !== oldest_det.determinant ||
                    m_tuser !== oldest_det.zero_pivot) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("determinant mismatch: exp %0d flag %0b, got %0d flag %0b",
                                 $signed(oldest_det.determinant), oldest_det.zero_pivot,
                                 $signed(m_tdata[DET_W-1:0]), m_tuser);
                end
            end
        end
    end

    // Stimulus: directed table first, then random matrices
    initial begin
        int               scenario;
        int               kind;
        int               count;
        int               pick;
        int               swap;
        value_mix_t       mix;
        logic [VAL_W-1:0] fresh [CELLS];
        int               fill_order [CELLS-1];

        //       value  pos  typed  determinant   zero_pivot
        // unit upper-triangular matrix with corner values and 256 above the diagonal
        add_row(    1,   0,  0,            0,  0);
        add_row(  511,   1,  0,            0,  0);
        add_row( -512,   2,  0,            0,  0);
        add_row(   -1,   3,  0,            0,  0);
        add_row(    0,   4,  0,            0,  0);
        add_row(    1,   5,  0,            0,  0);
        add_row(  511,   6,  0,            0,  0);
        add_row( -512,   7,  0,            0,  0);
        add_row(    0,   8,  0,            0,  0);
        add_row(    0,   9,  0,            0,  0);
        add_row(    1,  10,  0,            0,  0);
        add_row(  256,  11,  0,            0,  0);
        add_row(    0,  12,  0,            0,  0);
        add_row(    0,  13,  0,            0,  0);
        add_row(    0,  14,  0,            0,  0);
        add_row(    1,  15,  1,            1,  0);
        // a00 zero: elimination stops at the first pivot
        add_row(    0,   0,  0,            0,  0);
        add_row(    1,  15,  1,            0,  1);
        // a00 back, a11 zero: reduced second pivot is zero
        add_row(    1,   0,  0,            0,  0);
        add_row(    0,   5,  0,            0,  0);
        add_row(    1,  15,  1,            0,  1);
        // diagonal of -512: largest triangular determinant, 2^36
        add_row( -512,   0,  0,            0,  0);
        add_row( -512,   5,  0,            0,  0);
        add_row( -512,  10,  0,            0,  0);
        add_row( -512,  15,  1,  64'sd68719476736,  0);
        // a33 zero: a true zero determinant, flag stays clear
        add_row(    0,  15,  1,            0,  0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (load_table[r])
            send_entry(load_table[r].value, load_table[r].position,
                       load_table[r].typed, load_table[r].result);

        scenario = 0;
        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 5) == 0);
            mix     = value_mix_t'($urandom_range(0, 3));
            // hold the sender off until the pipe has fully drained
            if (scenario % 25 == 3 && expected_dets.size() != 0) begin
                s_tvalid <= 1'b0;
                while (expected_dets.size() != 0) @(posedge aclk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // full reload in shuffled order, position 15 last
                foreach (fresh[c])
                    fresh[c] = draw_value(mix);
                if ($urandom_range(0, 7) == 0)
                    for (int c = 0; c < ORDER; c++)
                        fresh[3 * ORDER + c] = fresh[2 * ORDER + c];   // row 3 = row 2
                foreach (fill_order[c])
                    fill_order[c] = c;
                for (int c = CELLS - 2; c > 0; c--) begin
                    pick             = $urandom_range(0, c);
                    swap             = fill_order[c];
                    fill_order[c]    = fill_order[pick];
                    fill_order[pick] = swap;
                end
                foreach (fill_order[c])
                    send_entry(fresh[fill_order[c]], POS_W'(fill_order[c]), 1'b0, '0);
                send_entry(fresh[CELLS - 1], LAST_POS, 1'b0, '0);
            end else if (kind < 85) begin
                // touch up a few stored entries and recompute
                count = $urandom_range(0, 4);
                repeat (count)
                    send_entry(draw_value(mix), POS_W'($urandom_range(0, CELLS - 2)), 1'b0, '0);
                send_entry(draw_value(mix), LAST_POS, 1'b0, '0);
            end else begin
                // loads that start nothing
                count = $urandom_range(1, 6);
                repeat (count)
                    send_entry(draw_value(MIX_FULL), POS_W'($urandom_range(0, CELLS - 2)),
                               1'b0, '0);
            end
            scenario++;
        end
        s_tvalid <= 1'b0;

        while (expected_dets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
